@@ src/htbg_pkg.sv @@
// Package with the shared constants, widths and the harmonic weight table of the tone generator.
`default_nettype none

package htbg_pkg;

  localparam int PHASE_W  = 32;
  localparam int LEN_W    = 24;
  localparam int SAMPLE_W = 16;
  localparam int SINE_W   = 15;
  localparam int ACC_W    = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST_LENGTH = 2'd1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET   = 32'd59055800;
  localparam logic [LEN_W-1:0]   BURST_LENGTH_RESET = 24'd8000;

  localparam int ATTACK_SAMPLES_DEF   = 100;
  localparam int RELEASE_SAMPLES_DEF  = 200;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int QUOT_W    = 16;
  localparam int DIGIT_W   = 2;
  localparam int DIV_STEPS = QUOT_W / DIGIT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SINE_W-1:0] W_FUND   = 15'd19661;
  localparam logic [SINE_W-1:0] W_SECOND = 15'd6554;
  localparam logic [SINE_W-1:0] W_THIRD  = 15'd3277;

  function automatic logic [SINE_W-1:0] weight_of(input logic [1:0] harm);
    logic [SINE_W-1:0] w;
    case (harm)
      2'd0:    w = W_FUND;
      2'd1:    w = W_SECOND;
      default: w = W_THIRD;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/htbg_req_if.sv @@
// Request channel carrying the restart field of one sample request.
`default_nettype none

interface htbg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ src/htbg_res_if.sv @@
// Result channel carrying one audio sample with its burst flags.
`default_nettype none

interface htbg_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [htbg_pkg::SAMPLE_W-1:0] sample_value;
  logic                                last_sample;
  logic                                done_res;

  modport source (output valid, output sample_value, output last_sample, output done_res,
                  input ready);
  modport sink (input valid, input sample_value, input last_sample, input done_res,
                output ready);
endinterface

`default_nettype wire

@@ src/htbg_cfg_if.sv @@
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface htbg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [htbg_pkg::CFG_INDEX_W-1:0]    index;
  logic [htbg_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/htbg_sine_rom.sv @@
// Quarter-wave sine table in Q15, built at elaboration, with a registered read port.
`default_nettype none

module htbg_sine_rom #(
  parameter int DEPTH = htbg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic [$clog2(DEPTH+1)-1:0]      addr,
  output logic      [htbg_pkg::SINE_W-1:0]     data
);

  logic [htbg_pkg::SINE_W-1:0] rom [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam longint unsigned X  = (64'(k) * htbg_pkg::HALF_PI_Q30) / DEPTH;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
    localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint SC = (S < 0) ? 64'sd0 : S;
    localparam longint Q  = (SC * 32767 + 64'sd536870912) >>> 30;
    localparam logic [htbg_pkg::SINE_W-1:0] V =
      (Q > 32767) ? 15'd32767 : htbg_pkg::SINE_W'(Q);
    assign rom[k] = V;
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

`default_nettype wire

@@ src/htbg_divider.sv @@
// Digit-serial restoring divider that yields the sample magnitude two quotient bits per cycle.
`default_nettype none

module htbg_divider #(
  parameter int NUM_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [NUM_W:0]                rem_init,
  input  wire logic [htbg_pkg::QUOT_W-1:0]   bits,
  input  wire logic [NUM_W-1:0]              den,
  output logic                               done,
  output logic      [htbg_pkg::QUOT_W-1:0]   quot
);

  localparam int REM_W = NUM_W + 1;

  logic                               busy;
  logic [htbg_pkg::DIV_CNT_W-1:0]     cnt;
  logic [REM_W-1:0]                   rem;
  logic [htbg_pkg::QUOT_W-1:0]        sr;
  logic [NUM_W-1:0]                   dvs;
  logic [REM_W-1:0]                   rem_next;
  logic [htbg_pkg::QUOT_W-1:0]        sr_next;
  logic [htbg_pkg::QUOT_W-1:0]        quot_next;

  always_comb begin
    logic [REM_W-1:0] t;
    rem_next  = rem;
    sr_next   = sr;
    quot_next = quot;
    for (int j = 0; j < htbg_pkg::DIGIT_W; j++) begin
      t       = {rem_next[REM_W-2:0], sr_next[htbg_pkg::QUOT_W-1]};
      sr_next = {sr_next[htbg_pkg::QUOT_W-2:0], 1'b0};
      if (t >= REM_W'(dvs)) begin
        rem_next  = t - REM_W'(dvs);
        quot_next = {quot_next[htbg_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem_next  = t;
        quot_next = {quot_next[htbg_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = busy && (cnt == htbg_pkg::DIV_CNT_W'(htbg_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= rem_init;
      sr   <= bits;
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      sr   <= sr_next;
      quot <= quot_next;
      cnt  <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/harmonic_tone_burst_generator_unit.sv @@
// Top level of the harmonic tone burst generator: sequencer, sine pass and envelope.
// After its request is accepted, a sample inside the burst passes through the sine lookups and
// weighting, the envelope multiply, the divider and finally the output register.
// A new request is taken only once the previous sample has been written to the output register.
// Silence after the burst end skips the sine pass and the divider and goes straight to the output register.
// Synchronous reset restores register defaults, zeroes the phase and parks the index at the end.
`default_nettype none

module harmonic_tone_burst_generator_unit #(
  parameter int ATTACK_SAMPLES   = htbg_pkg::ATTACK_SAMPLES_DEF,
  parameter int RELEASE_SAMPLES  = htbg_pkg::RELEASE_SAMPLES_DEF,
  parameter int SINE_TABLE_DEPTH = htbg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  htbg_req_if.sink   req,
  htbg_res_if.source res,
  htbg_cfg_if.sink   cfg
);

  localparam int ENV_MAX    = (ATTACK_SAMPLES > RELEASE_SAMPLES) ? ATTACK_SAMPLES
                                                                 : RELEASE_SAMPLES;
  localparam int NUM_W      = $clog2(ENV_MAX + 1);
  localparam int REM_W      = NUM_W + 1;
  localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_PROD_W = 30 + ADDR_W;
  localparam int MPROD_W    = htbg_pkg::ACC_W + NUM_W;
  localparam int PROD_W     = 2 * htbg_pkg::SINE_W;

  typedef enum logic [2:0] {S_IDLE, S_SINE, S_PROD, S_DIV, S_OUT} state_t;

  state_t                               state;
  logic [2:0]                           cnt;
  logic [htbg_pkg::PHASE_W-1:0]         phase_step;
  logic [htbg_pkg::LEN_W-1:0]           burst_length;
  logic [htbg_pkg::LEN_W-1:0]           sample_index;
  logic [htbg_pkg::PHASE_W-1:0]         phase_acc;
  logic [htbg_pkg::PHASE_W-1:0]         pbase;
  logic [htbg_pkg::PHASE_W-1:0]         hphase;
  logic [NUM_W-1:0]                     num;
  logic [NUM_W-1:0]                     den;
  logic                                 last_flag;
  logic                                 done_flag;
  logic                                 neg_rd;
  logic                                 neg;
  logic signed [htbg_pkg::ACC_W-1:0]    wprod;
  logic signed [htbg_pkg::ACC_W-1:0]    acc;

  logic                                 accept;
  logic [htbg_pkg::LEN_W-1:0]           ie;
  logic [htbg_pkg::PHASE_W-1:0]         pe;
  logic                                 finished;
  logic                                 in_attack;
  logic                                 in_release;
  logic signed [htbg_pkg::LEN_W:0]      rel_start;
  logic [NUM_W-1:0]                     num_next;
  logic [NUM_W-1:0]                     den_next;
  logic [IDX_PROD_W-1:0]                idx_prod;
  logic [ADDR_W-1:0]                    idx;
  logic [ADDR_W-1:0]                    rom_addr;
  logic [htbg_pkg::SINE_W-1:0]          rom_data;
  logic [PROD_W-1:0]                    mag_w;
  logic signed [htbg_pkg::ACC_W-1:0]    wprod_next;
  logic [htbg_pkg::ACC_W-1:0]           amag;
  logic [MPROD_W-1:0]                   mprod;
  logic                                 div_start;
  logic                                 div_done;
  logic [htbg_pkg::QUOT_W-1:0]          quot;
  logic                                 out_free;

  assign accept    = (state == S_IDLE) && req.valid;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign ie       = req.restart ? '0 : sample_index;
  assign pe       = req.restart ? '0 : phase_acc;
  assign finished = (ie >= burst_length);

  assign rel_start  = $signed({1'b0, burst_length}) - (htbg_pkg::LEN_W + 1)'(RELEASE_SAMPLES);
  assign in_attack  = (32'(ie) < 32'(ATTACK_SAMPLES));
  assign in_release = ($signed({1'b0, ie}) > rel_start);

  always_comb begin
    if (in_attack) begin
      num_next = NUM_W'(ie);
      den_next = NUM_W'(ATTACK_SAMPLES);
    end else if (in_release) begin
      num_next = NUM_W'(burst_length - ie);
      den_next = NUM_W'(RELEASE_SAMPLES);
    end else begin
      num_next = NUM_W'(1);
      den_next = NUM_W'(1);
    end
  end

  assign idx_prod = IDX_PROD_W'(hphase[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[IDX_PROD_W-1:30];
  assign rom_addr = hphase[30] ? (ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;

  htbg_sine_rom #(
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign mag_w      = PROD_W'(rom_data) * PROD_W'(htbg_pkg::weight_of(2'(cnt - 3'd1)));
  assign wprod_next = neg_rd ? -$signed({2'b00, mag_w}) : $signed({2'b00, mag_w});

  assign amag      = acc[htbg_pkg::ACC_W-1] ? 32'(-acc) : 32'(acc);
  assign mprod     = MPROD_W'(amag) * MPROD_W'(num);
  assign div_start = (state == S_PROD);

  htbg_divider #(
    .NUM_W(NUM_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (REM_W'(mprod >> 32)),
    .bits     (mprod[31:16]),
    .den      (den),
    .done     (div_done),
    .quot     (quot)
  );

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      phase_step   <= htbg_pkg::PHASE_STEP_RESET;
      burst_length <= htbg_pkg::BURST_LENGTH_RESET;
      sample_index <= htbg_pkg::BURST_LENGTH_RESET;
      phase_acc    <= '0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          htbg_pkg::REG_PHASE_STEP:   phase_step   <= cfg.data;
          htbg_pkg::REG_BURST_LENGTH: burst_length <= cfg.data[htbg_pkg::LEN_W-1:0];
          default: ;
        endcase
      end

      if (res.ready && (state != S_OUT)) begin
        res.valid <= 1'b0;
      end

      neg_rd <= hphase[31];
      wprod  <= wprod_next;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt       <= '0;
            pbase     <= pe;
            hphase    <= pe;
            acc       <= '0;
            num       <= num_next;
            den       <= den_next;
            done_flag <= finished;
            last_flag <= !finished && ((ie + 24'd1) == burst_length);
            if (finished) begin
              sample_index <= ie;
              phase_acc    <= pe;
              state        <= S_OUT;
            end else begin
              sample_index <= ie + 24'd1;
              phase_acc    <= pe + phase_step;
              state        <= S_SINE;
            end
          end
        end
        S_SINE: begin
          cnt <= cnt + 3'd1;
          if (cnt < 3'd3) begin
            hphase <= hphase + pbase;
          end
          if (cnt >= 3'd2) begin
            acc <= acc + wprod;
          end
          if (cnt == 3'd4) begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          neg   <= acc[htbg_pkg::ACC_W-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res.valid       <= 1'b1;
            res.last_sample <= last_flag;
            res.done_res    <= done_flag;
            if (done_flag) begin
              res.sample_value <= '0;
            end else if (neg) begin
              res.sample_value <= -$signed(quot);
            end else begin
              res.sample_value <= $signed(quot);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/htbg_checker.sv @@
// Port-level checks on the result channel of the tone generator, bound to the top level.
`default_nettype none

module htbg_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  res_valid,
  input wire logic                                  res_ready,
  input wire logic signed [htbg_pkg::SAMPLE_W-1:0]  sample_value,
  input wire logic                                  last_sample,
  input wire logic                                  done_res
);

  localparam logic signed [htbg_pkg::SAMPLE_W-1:0] PEAK = 16'sd14746;

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> (sample_value == '0) && !last_sample)
    else $error("silence result carries a sample or a last flag");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (sample_value <= PEAK) && (sample_value >= -PEAK))
    else $error("sample beyond the tone peak");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(sample_value)
                                && $stable(last_sample) && $stable(done_res))
    else $error("stalled result changed");

endmodule

bind harmonic_tone_burst_generator_unit htbg_checker u_htbg_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .sample_value (res.sample_value),
  .last_sample  (res.last_sample),
  .done_res     (res.done_res)
);

`default_nettype wire
